// File: rtl/qspg_pkg.sv
// ----------------------------------------------------------------------------
// qspg_pkg
// Shared types, constants and helpers for the queued step pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package qspg_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] POS_BIAS         = 32'h4000_0000;
    localparam logic [23:0] LATE_LIMIT_RESET = 24'd72000;

    // raw function codes on the command channel
    localparam logic [2:0] FUNC_TICK        = 3'd0;
    localparam logic [2:0] FUNC_MOVE        = 3'd1;
    localparam logic [2:0] FUNC_SET_DIR     = 3'd2;
    localparam logic [2:0] FUNC_RESET_CLOCK = 3'd3;
    localparam logic [2:0] FUNC_STOP        = 3'd4;
    localparam logic [2:0] FUNC_QUERY       = 3'd5;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_COUNT  = 3'd1;
    localparam logic [2:0] STATUS_RESET_BUSY = 3'd2;
    localparam logic [2:0] STATUS_TOO_LATE   = 3'd3;
    localparam logic [2:0] STATUS_QUEUE_FULL = 3'd4;

    localparam logic [7:0] REG_STEP_PULSE = 8'd0;
    localparam logic [7:0] REG_INVERT     = 8'd1;
    localparam logic [7:0] REG_LATE_LIMIT = 8'd2;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_MOVE,
        OP_SET_DIR,
        OP_RESET_CLOCK,
        OP_STOP,
        OP_QUERY,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t          op;
        logic         count_zero;
        logic [31:0]  now_time;
        logic [31:0]  move_interval;
        logic [15:0]  move_count;
        logic [15:0]  move_add;
        logic         next_dir;
        logic [31:0]  clock_value;
    } op_item_t;

    typedef struct packed {
        logic         step_out;
        logic         dir_out;
        logic         stepped;
        logic         active;
        logic [31:0]  position_out;
        logic [2:0]   status;
        logic         halted;
        logic [31:0]  wake_out;
    } result_t;

    // a is before b when the wrapped difference is negative
    function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/qspg_if.sv
// ----------------------------------------------------------------------------
// qspg_if
// Command, result and configuration channels of the step pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

interface qspg_cmd_if;
    logic         valid;
    logic         ready;
    logic [2:0]   func;
    logic [31:0]  now_time;
    logic [31:0]  move_interval;
    logic [15:0]  move_count;
    logic signed [15:0] move_add;
    logic         next_dir;
    logic [31:0]  clock_value;

    modport source (output valid, func, now_time, move_interval, move_count, move_add,
                    next_dir, clock_value, input ready);
    modport sink   (input valid, func, now_time, move_interval, move_count, move_add,
                    next_dir, clock_value, output ready);
endinterface

interface qspg_rsp_if;
    logic         valid;
    logic         ready;
    logic         step_out;
    logic         dir_out;
    logic         stepped;
    logic         active;
    logic signed [31:0] position_out;
    logic [2:0]   status;
    logic         halted;
    logic [31:0]  wake_out;

    modport source (output valid, step_out, dir_out, stepped, active, position_out, status,
                    halted, wake_out, input ready);
    modport sink   (input valid, step_out, dir_out, stepped, active, position_out, status,
                    halted, wake_out, output ready);
endinterface

interface qspg_cfg_if;
    logic         valid;
    logic         ready;
    logic [7:0]   index;
    logic [31:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/qspg_front.sv
// ----------------------------------------------------------------------------
// qspg_front
// Takes command beats and classifies them into internal operations.
// ----------------------------------------------------------------------------
`default_nettype none

module qspg_front (
    qspg_cmd_if.sink            cmd,
    output logic                item_valid,
    input  logic                item_ready,
    output qspg_pkg::op_item_t  item
);

    qspg_pkg::op_t op;

    always_comb
    begin
        unique case (cmd.func)
            qspg_pkg::FUNC_TICK:        op = qspg_pkg::OP_TICK;
            qspg_pkg::FUNC_MOVE:        op = qspg_pkg::OP_MOVE;
            qspg_pkg::FUNC_SET_DIR:     op = qspg_pkg::OP_SET_DIR;
            qspg_pkg::FUNC_RESET_CLOCK: op = qspg_pkg::OP_RESET_CLOCK;
            qspg_pkg::FUNC_STOP:        op = qspg_pkg::OP_STOP;
            qspg_pkg::FUNC_QUERY:       op = qspg_pkg::OP_QUERY;
            default:                    op = qspg_pkg::OP_NOP;
        endcase
    end

    assign item.op            = op;
    assign item.count_zero    = (cmd.move_count == 16'd0);
    assign item.now_time      = cmd.now_time;
    assign item.move_interval = cmd.move_interval;
    assign item.move_count    = cmd.move_count;
    assign item.move_add      = cmd.move_add;
    assign item.next_dir      = cmd.next_dir;
    assign item.clock_value   = cmd.clock_value;

    assign item_valid = cmd.valid;
    assign cmd.ready  = item_ready;

endmodule

`default_nettype wire

// File: rtl/qspg_fifo.sv
// ----------------------------------------------------------------------------
// qspg_fifo
// Two-entry operation queue between the front and the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

module qspg_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  qspg_pkg::op_item_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output qspg_pkg::op_item_t  pop_data
);

    qspg_pkg::op_item_t entry_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/qspg_exec.sv
// ----------------------------------------------------------------------------
// qspg_exec
// Execute unit: step timing, move queue, position, halt logic, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qspg_exec (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  qspg_pkg::op_item_t  item,
    qspg_rsp_if.source          rsp,
    qspg_cfg_if.sink            cfg
);

    localparam int QIDX_W = qspg_pkg::QIDX_W;
    localparam int QCNT_W = qspg_pkg::QCNT_W;
    localparam logic [QIDX_W-1:0] HEAD_LAST = QIDX_W'(qspg_pkg::QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FILL_FULL = QCNT_W'(qspg_pkg::QUEUE_DEPTH);
    localparam logic [QCNT_W:0]   DEPTH_EXT = (QCNT_W + 1)'(qspg_pkg::QUEUE_DEPTH);

    // configuration
    logic [19:0] step_pulse_reg;
    logic        invert_reg;
    logic [23:0] late_limit_reg;

    // step state
    logic        step_level_reg, step_level_next;
    logic        dir_level_reg, dir_level_next;
    logic [31:0] bpos_reg, bpos_next;
    logic [17:0] edges_reg, edges_next;
    logic [31:0] cur_iv_reg, cur_iv_next;
    logic [15:0] cur_add_reg, cur_add_next;
    logic [31:0] next_at_reg, next_at_next;
    logic [31:0] wake_reg, wake_next;
    logic        df_last_reg, df_last_next;
    logic        df_next_reg, df_next_next;
    logic        df_reset_reg, df_reset_next;
    logic [QIDX_W-1:0] head_reg, head_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic        halt_reg, halt_next;

    // move queue register file
    logic [31:0] q_iv_reg  [qspg_pkg::QUEUE_DEPTH];
    logic [32:0] q_cad_reg [qspg_pkg::QUEUE_DEPTH];
    logic              q_we;
    logic [QIDX_W-1:0] q_waddr;
    logic [32:0]       q_wcad;

    qspg_pkg::result_t res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic              exec;

    assign item_ready = !out_valid_reg || rsp.ready;
    assign exec       = item_valid && item_ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        logic [31:0] min_next;
        logic [31:0] sched;
        logic [31:0] late;
        logic [31:0] mag_cur;
        logic [31:0] stop_mag;
        logic [17:0] e1;
        logic        do_load;
        logic        ld_from_in;
        logic [31:0] ld_iv;
        logic [32:0] ld_cad;
        logic [31:0] ld_next;
        logic        fl_last;
        logic        mdir;
        logic        stop_req;
        logic        halt_req;
        logic        stepped;
        logic [2:0]  status;
        logic [31:0] pos;
        logic [QCNT_W:0] slot_sum;

        step_level_next = step_level_reg;
        dir_level_next  = dir_level_reg;
        bpos_next       = bpos_reg;
        edges_next      = edges_reg;
        cur_iv_next     = cur_iv_reg;
        cur_add_next    = cur_add_reg;
        next_at_next    = next_at_reg;
        wake_next       = wake_reg;
        df_last_next    = df_last_reg;
        df_next_next    = df_next_reg;
        df_reset_next   = df_reset_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        halt_next       = halt_reg;

        q_we     = 1'b0;
        slot_sum = {1'b0, head_reg} + {1'b0, fill_reg};
        if (slot_sum >= DEPTH_EXT)
        begin
            slot_sum = slot_sum - DEPTH_EXT;
        end
        q_waddr  = slot_sum[QIDX_W-1:0];
        fl_last  = df_last_reg ^ (df_last_reg ^ df_next_reg);
        mdir     = df_last_reg ^ df_next_reg;
        q_wcad   = {mdir, item.move_add, item.move_count};

        min_next = item.now_time + {12'd0, step_pulse_reg};
        e1       = edges_reg - 18'd1;
        sched    = next_at_reg + cur_iv_reg;
        mag_cur  = qspg_pkg::abs32(bpos_reg - {15'd0, edges_reg[17:1]});
        stop_mag = mag_cur;
        do_load  = 1'b0;
        ld_from_in = (fill_reg == '0);
        ld_iv    = ld_from_in ? item.move_interval : q_iv_reg[head_reg];
        ld_cad   = ld_from_in ? q_wcad : q_cad_reg[head_reg];
        ld_next  = next_at_reg + ld_iv;
        late     = min_next - ld_next;
        stop_req = 1'b0;
        halt_req = 1'b0;
        stepped  = 1'b0;
        status   = qspg_pkg::STATUS_OK;
        pos      = 32'd0;

        if (exec)
        begin
            if (item.op == qspg_pkg::OP_QUERY)
            begin
                pos = mag_cur - qspg_pkg::POS_BIAS;
            end
            else if (!halt_reg)
            begin
                unique case (item.op)
                    qspg_pkg::OP_TICK:
                    begin
                        if (edges_reg != 18'd0 && !qspg_pkg::is_before(item.now_time, wake_reg))
                        begin
                            step_level_next = ~step_level_reg;
                            stepped         = 1'b1;
                            edges_next      = e1;
                            if (e1[0])
                            begin
                                wake_next = min_next;
                            end
                            else if (e1 != 18'd0)
                            begin
                                next_at_next = sched;
                                cur_iv_next  = cur_iv_reg + qspg_pkg::sext16(cur_add_reg);
                                wake_next    = qspg_pkg::is_before(sched, min_next)
                                             ? min_next : sched;
                            end
                            else if (fill_reg != '0)
                            begin
                                do_load = 1'b1;
                                if (qspg_pkg::is_before(ld_next, min_next))
                                begin
                                    if (late > {8'd0, late_limit_reg})
                                    begin
                                        // load leaves |bpos| unchanged at edges/2 offset
                                        stop_mag = qspg_pkg::abs32(bpos_reg);
                                        stop_req = 1'b1;
                                        halt_req = 1'b1;
                                        status   = qspg_pkg::STATUS_TOO_LATE;
                                    end
                                    else
                                    begin
                                        wake_next = min_next;
                                    end
                                end
                            end
                        end
                    end
                    qspg_pkg::OP_MOVE:
                    begin
                        if (item.count_zero)
                        begin
                            stop_req = 1'b1;
                            halt_req = 1'b1;
                            status   = qspg_pkg::STATUS_BAD_COUNT;
                        end
                        else if (edges_reg == 18'd0 && df_reset_reg)
                        begin
                            // dropped until the clock is reset
                        end
                        else if (fill_reg == FILL_FULL)
                        begin
                            status = qspg_pkg::STATUS_QUEUE_FULL;
                        end
                        else
                        begin
                            df_last_next = fl_last;
                            q_we         = 1'b1;
                            fill_next    = fill_reg + QCNT_W'(1);
                            if (edges_reg == 18'd0)
                            begin
                                do_load = 1'b1;
                            end
                        end
                    end
                    qspg_pkg::OP_SET_DIR:
                    begin
                        df_next_next = item.next_dir;
                    end
                    qspg_pkg::OP_RESET_CLOCK:
                    begin
                        if (edges_reg != 18'd0)
                        begin
                            stop_req = 1'b1;
                            halt_req = 1'b1;
                            status   = qspg_pkg::STATUS_RESET_BUSY;
                        end
                        else
                        begin
                            next_at_next  = item.clock_value;
                            wake_next     = item.clock_value;
                            df_reset_next = 1'b0;
                        end
                    end
                    qspg_pkg::OP_STOP:
                    begin
                        stop_req = 1'b1;
                    end
                    qspg_pkg::OP_QUERY, qspg_pkg::OP_NOP:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (do_load)
        begin
            head_next    = (head_reg == HEAD_LAST) ? '0 : head_reg + QIDX_W'(1);
            fill_next    = fill_next - QCNT_W'(1);
            cur_add_next = ld_cad[31:16];
            next_at_next = ld_next;
            if (!(item.op == qspg_pkg::OP_TICK && qspg_pkg::is_before(ld_next, min_next)))
            begin
                wake_next = ld_next;
            end
            edges_next   = {1'b0, ld_cad[15:0], 1'b0};
            cur_iv_next  = ld_iv + qspg_pkg::sext16(ld_cad[31:16]);
            if (ld_cad[32])
            begin
                bpos_next      = (32'd0 - bpos_reg) + {16'd0, ld_cad[15:0]};
                dir_level_next = ~dir_level_reg;
            end
            else
            begin
                bpos_next = bpos_reg + {16'd0, ld_cad[15:0]};
            end
        end

        if (stop_req)
        begin
            next_at_next    = 32'd0;
            wake_next       = 32'd0;
            bpos_next       = 32'd0 - stop_mag;
            edges_next      = 18'd0;
            df_last_next    = 1'b0;
            df_next_next    = 1'b0;
            df_reset_next   = 1'b1;
            dir_level_next  = 1'b0;
            step_level_next = invert_reg;
            head_next       = '0;
            fill_next       = '0;
            if (halt_req)
            begin
                halt_next = 1'b1;
            end
        end

        // step idles at the new polarity only while no edges are pending
        if (cfg.valid && cfg.index == qspg_pkg::REG_INVERT && edges_reg == 18'd0)
        begin
            step_level_next = cfg.data[0];
        end

        res_next.step_out     = step_level_next;
        res_next.dir_out      = dir_level_next;
        res_next.stepped      = stepped;
        res_next.active       = (edges_next != 18'd0);
        res_next.position_out = pos;
        res_next.status       = status;
        res_next.halted       = halt_next;
        res_next.wake_out     = wake_next;

        out_valid_next = exec || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_pulse_reg <= 20'd0;
            invert_reg     <= 1'b0;
            late_limit_reg <= qspg_pkg::LATE_LIMIT_RESET;
            step_level_reg <= 1'b0;
            dir_level_reg  <= 1'b0;
            bpos_reg       <= 32'd0 - qspg_pkg::POS_BIAS;
            edges_reg      <= 18'd0;
            cur_iv_reg     <= 32'd0;
            cur_add_reg    <= 16'd0;
            next_at_reg    <= 32'd0;
            wake_reg       <= 32'd0;
            df_last_reg    <= 1'b0;
            df_next_reg    <= 1'b0;
            df_reset_reg   <= 1'b0;
            head_reg       <= '0;
            fill_reg       <= '0;
            halt_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                priority case (cfg.index)
                    qspg_pkg::REG_STEP_PULSE: step_pulse_reg <= cfg.data[19:0];
                    qspg_pkg::REG_INVERT:     invert_reg     <= cfg.data[0];
                    qspg_pkg::REG_LATE_LIMIT: late_limit_reg <= cfg.data[23:0];
                    default:
                    begin
                    end
                endcase
            end
            step_level_reg <= step_level_next;
            dir_level_reg  <= dir_level_next;
            bpos_reg       <= bpos_next;
            edges_reg      <= edges_next;
            cur_iv_reg     <= cur_iv_next;
            cur_add_reg    <= cur_add_next;
            next_at_reg    <= next_at_next;
            wake_reg       <= wake_next;
            df_last_reg    <= df_last_next;
            df_next_reg    <= df_next_next;
            df_reset_reg   <= df_reset_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            halt_reg       <= halt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_iv_reg[q_waddr]  <= item.move_interval;
            q_cad_reg[q_waddr] <= q_wcad;
        end
        if (exec)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.step_out     = res_reg.step_out;
    assign rsp.dir_out      = res_reg.dir_out;
    assign rsp.stepped      = res_reg.stepped;
    assign rsp.active       = res_reg.active;
    assign rsp.position_out = res_reg.position_out;
    assign rsp.status       = res_reg.status;
    assign rsp.halted       = res_reg.halted;
    assign rsp.wake_out     = res_reg.wake_out;

endmodule

`default_nettype wire

// File: rtl/queued_step_pulse_generator_top.sv
// ----------------------------------------------------------------------------
// queued_step_pulse_generator_top
// Step/direction pulse generator with a move queue.
// ----------------------------------------------------------------------------
// One result beat per command beat. The block sustains one command per clock
// while rsp is ready: every operation, including a step that loads the next
// queued move, is resolved combinationally by the execute unit, so its state
// loop sets the rate. A command reaches rsp through a two-entry command queue
// and then the result register; rsp stalls back up into the queue without
// losing beats. Configuration writes are taken every cycle and should be
// issued only while no command is in flight. The move queue holds 16 moves.
`default_nettype none

module queued_step_pulse_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    qspg_cmd_if.sink    cmd,
    qspg_rsp_if.source  rsp,
    qspg_cfg_if.sink    cfg
);

    qspg_pkg::op_item_t front_item;
    qspg_pkg::op_item_t exec_item;
    logic               front_valid, front_ready;
    logic               exec_valid, exec_ready;

    qspg_front u_front (
        .cmd        (cmd),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    qspg_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_item),
        .pop_valid  (exec_valid),
        .pop_ready  (exec_ready),
        .pop_data   (exec_item)
    );

    qspg_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (exec_valid),
        .item_ready (exec_ready),
        .item       (exec_item),
        .rsp        (rsp),
        .cfg        (cfg)
    );

endmodule

`default_nettype wire
